[src/cdq_pkg.sv]
// Package: sizes, operation codes, shared types and helpers of the circular deque.
package cdq_pkg;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned IdxW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned CapW  = 11;
  localparam int unsigned WordW = 32;
  localparam int unsigned OpW   = 3;

  localparam logic [CapW-1:0]  CapReset  = CapW'(1024);
  localparam logic [WordW-1:0] EmptyWord = '1;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_QUERY      = 3'd4
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } st_e;

  // Request from the controller to the slot memory
  typedef struct packed {
    logic             we;
    logic [IdxW-1:0]  waddr;
    logic [WordW-1:0] wdata;
    logic             re;
    logic [IdxW-1:0]  raddr;
  } ram_req_t;

  // Clamp the capacity register to the built ring: zero acts as one
  function automatic logic [CntW-1:0] ring_size(input logic [CapW-1:0] cap);
    logic [CntW-1:0] res;
    if (cap == '0) begin
      res = CntW'(1);
    end else if (32'(cap) > DEPTH) begin
      res = CntW'(DEPTH);
    end else begin
      res = CntW'(cap);
    end
    return res;
  endfunction

endpackage

[src/cdq_if.sv]
// Interfaces: request, result and capacity channels of the circular deque.
interface cdq_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        operation;
  logic signed [31:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface cdq_out_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic signed [31:0] front_value;
  logic signed [31:0] rear_value;
  logic               is_empty;
  logic               is_full;

  modport source (output valid, output accepted, output front_value, output rear_value,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input accepted, input front_value, input rear_value,
                  input is_empty, input is_full, output ready);
endinterface

interface cdq_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

[src/circular_deque_core.sv]
// Top level of the circular deque: controller and slot memory.
//
// A double-ended queue of 32-bit words held in a ring of slots in one memory.
// in_i carries one word per request: an operation (push front, push rear,
// pop front, pop rear, query; other codes act as a query) and a value used
// by pushes. out_o returns one word per request: accepted, the front and
// rear words after the step (all ones when empty) and empty/full flags.
// cfg_i writes the capacity (0 acts as 1, above the built depth acts as the
// depth) and empties the deque; write it only while the block is idle.
// Pushes, refused operations, queries and a pop that drains the deque give
// their result in the cycle after acceptance; any other pop first reads the
// new end slot from the memory and registers its result after that read.
// No new request is taken while a pop waits for that memory read.
// Reset empties the deque and sets the capacity to 1024; slot contents are
// not cleared and need no clearing pass. A result waits in the output
// register while the receiver stalls; no new request is taken until that
// register is free or being emptied in the same cycle.
module circular_deque_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  cdq_in_if.sink    in_i,
  cdq_out_if.source out_o,
  cdq_cfg_if.sink   cfg_i
);
  import cdq_pkg::*;

  ram_req_t         ram_req;
  logic [WordW-1:0] ram_rdata;

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .cfg_i       (cfg_i),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  cdq_ram #(
    .Width (WordW),
    .Depth (DEPTH),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

endmodule

[src/cdq_ram.sv]
// Generic single-write, single-read memory with registered read data.
module cdq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/cdq_ctrl.sv]
// Controller: indices, count, end-word caches, sequencer and result register.
module cdq_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  cdq_in_if.sink                   in_i,
  cdq_out_if.source                out_o,
  cdq_cfg_if.sink                  cfg_i,
  output cdq_pkg::ram_req_t        ram_req_o,
  input  logic [cdq_pkg::WordW-1:0] ram_rdata_i
);
  import cdq_pkg::*;

  st_e              state_q, state_d;
  logic [CapW-1:0]  cap_q;
  logic [IdxW-1:0]  fidx_q, fidx_d;
  logic [IdxW-1:0]  ridx_q, ridx_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WordW-1:0] fval_q, fval_d;
  logic [WordW-1:0] rval_q, rval_d;
  logic             pend_front_q, pend_front_d;
  logic             pend_full_q, pend_full_d;

  logic             out_valid_q, out_valid_d;
  logic             out_acc_q, out_acc_d;
  logic [WordW-1:0] out_front_q, out_front_d;
  logic [WordW-1:0] out_rear_q, out_rear_d;
  logic             out_empty_q, out_empty_d;
  logic             out_full_q, out_full_d;

  logic [CntW-1:0]  size;
  logic [IdxW-1:0]  last_idx;
  logic             in_fire;
  logic             out_free;
  logic             is_empty_now;
  logic             is_full_now;
  logic             ok;
  logic             load_direct;
  op_e              op;

  assign size         = ring_size(cap_q);
  assign last_idx     = IdxW'(size - CntW'(1));
  assign out_free     = !out_valid_q || out_o.ready;
  assign in_i.ready   = (state_q == ST_IDLE) && out_free;
  assign in_fire      = in_i.valid && in_i.ready;
  assign cfg_i.ready  = 1'b1;
  assign is_empty_now = (cnt_q == '0);
  assign is_full_now  = (cnt_q >= size);
  assign op           = op_e'(in_i.operation);

  // Next state, index arithmetic and memory requests
  always_comb begin
    state_d      = state_q;
    fidx_d       = fidx_q;
    ridx_d       = ridx_q;
    cnt_d        = cnt_q;
    fval_d       = fval_q;
    rval_d       = rval_q;
    pend_front_d = pend_front_q;
    pend_full_d  = pend_full_q;
    ram_req_o    = '0;
    ok           = 1'b1;
    load_direct  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          load_direct = 1'b1;
          case (op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
              if (is_full_now) begin
                ok = 1'b0;
              end else begin
                cnt_d           = cnt_q + CntW'(1);
                ram_req_o.we    = 1'b1;
                ram_req_o.wdata = WordW'(in_i.value);
                if (is_empty_now) begin
                  fidx_d          = '0;
                  ridx_d          = '0;
                  ram_req_o.waddr = '0;
                  fval_d          = WordW'(in_i.value);
                  rval_d          = WordW'(in_i.value);
                end else if (op == OP_PUSH_FRONT) begin
                  fidx_d          = (fidx_q == '0) ? last_idx : fidx_q - IdxW'(1);
                  ram_req_o.waddr = fidx_d;
                  fval_d          = WordW'(in_i.value);
                end else begin
                  ridx_d          = (CntW'(ridx_q) + CntW'(1) >= size) ? '0
                                                                       : ridx_q + IdxW'(1);
                  ram_req_o.waddr = ridx_d;
                  rval_d          = WordW'(in_i.value);
                end
              end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
              if (is_empty_now) begin
                ok = 1'b0;
              end else begin
                cnt_d = cnt_q - CntW'(1);
                if (cnt_q == CntW'(1)) begin
                  // Drained: return both indices to slot 0
                  fidx_d = '0;
                  ridx_d = '0;
                end else begin
                  // Fetch the new end word; the result waits in ST_READ for it
                  load_direct   = 1'b0;
                  state_d       = ST_READ;
                  ram_req_o.re  = 1'b1;
                  pend_full_d   = (cnt_d == size);
                  if (op == OP_POP_FRONT) begin
                    fidx_d          = (CntW'(fidx_q) + CntW'(1) >= size) ? '0
                                                                         : fidx_q + IdxW'(1);
                    ram_req_o.raddr = fidx_d;
                    pend_front_d    = 1'b1;
                  end else begin
                    ridx_d          = (ridx_q == '0) ? last_idx : ridx_q - IdxW'(1);
                    ram_req_o.raddr = ridx_d;
                    pend_front_d    = 1'b0;
                  end
                end
              end
            end
            default: begin
              ok = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
        if (pend_front_q) begin
          fval_d = ram_rdata_i;
        end else begin
          rval_d = ram_rdata_i;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result register: load on completion, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_acc_d   = out_acc_q;
    out_front_d = out_front_q;
    out_rear_d  = out_rear_q;
    out_empty_d = out_empty_q;
    out_full_d  = out_full_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_direct) begin
      out_valid_d = 1'b1;
      out_acc_d   = ok;
      out_empty_d = (cnt_d == '0);
      out_full_d  = (cnt_d == size);
      out_front_d = (cnt_d == '0) ? EmptyWord : fval_d;
      out_rear_d  = (cnt_d == '0) ? EmptyWord : rval_d;
    end else if (state_q == ST_READ) begin
      out_valid_d = 1'b1;
      out_acc_d   = 1'b1;
      out_empty_d = 1'b0;
      out_full_d  = pend_full_q;
      out_front_d = fval_d;
      out_rear_d  = rval_d;
    end
  end

  // Control state; a capacity write empties the deque
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CapReset;
      fidx_q      <= '0;
      ridx_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        cap_q  <= cfg_i.capacity;
        fidx_q <= '0;
        ridx_q <= '0;
        cnt_q  <= '0;
      end else begin
        fidx_q <= fidx_d;
        ridx_q <= ridx_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    fval_q       <= fval_d;
    rval_q       <= rval_d;
    pend_front_q <= pend_front_d;
    pend_full_q  <= pend_full_d;
    out_acc_q    <= out_acc_d;
    out_front_q  <= out_front_d;
    out_rear_q   <= out_rear_d;
    out_empty_q  <= out_empty_d;
    out_full_q   <= out_full_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.accepted    = out_acc_q;
  assign out_o.front_value = out_front_q;
  assign out_o.rear_value  = out_rear_q;
  assign out_o.is_empty    = out_empty_q;
  assign out_o.is_full     = out_full_q;

endmodule

[tb/circular_deque_core_test.sv]
// Self-checking testbench for the circular deque: directed cases, then random traffic.
module circular_deque_core_test;
  import cdq_pkg::*;

  // Operation codes the block does not define; they must act as a query
  localparam logic [OpW-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OpW-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OpW-1:0] OP_SPARE_HI = 3'd7;

  localparam logic [WordW-1:0] WordMin  = 32'h8000_0000;
  localparam logic [WordW-1:0] WordMax  = 32'h7FFF_FFFF;
  localparam logic [WordW-1:0] WordZero = 32'h0000_0000;

  localparam int unsigned IdlePct      = 28;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned ReportLimit  = 10;

  typedef struct packed {
    logic             accepted;
    logic [WordW-1:0] front_value;
    logic [WordW-1:0] rear_value;
    logic             is_empty;
    logic             is_full;
  } deque_view_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  cdq_in_if  deque_in ();
  cdq_out_if deque_out ();
  cdq_cfg_if deque_cfg ();

  circular_deque_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (deque_in),
    .out_o  (deque_out),
    .cfg_i  (deque_cfg)
  );

  // Shadow copy of the deque state
  logic [WordW-1:0] ring_mem [DEPTH];
  logic [IdxW-1:0]  head_idx;
  logic [IdxW-1:0]  tail_idx;
  logic [CntW-1:0]  fill;
  logic [CapW-1:0]  cap_reg;

  deque_view_t expected_views [$];
  int unsigned fail_count;
  int unsigned quiet_cycles;
  bit          steady;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Apply one operation to the shadow state and return the view that follows it
  function automatic deque_view_t step_deque(input logic [OpW-1:0] op,
                                             input logic [WordW-1:0] word);
    deque_view_t view;
    int unsigned span;
    if (cap_reg == '0) begin
      span = 1;
    end else if (cap_reg > DEPTH) begin
      span = DEPTH;
    end else begin
      span = 32'(cap_reg);
    end
    view.accepted = 1'b1;
    if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
      if (fill >= span) begin
        view.accepted = 1'b0;
      end else begin
        if (fill == '0) begin
          head_idx = '0;
          tail_idx = '0;
          ring_mem[0] = word;
        end else if (op == OP_PUSH_FRONT) begin
          head_idx = (head_idx == '0) ? IdxW'(span - 1) : head_idx - 1'b1;
          ring_mem[head_idx] = word;
        end else begin
          tail_idx = (tail_idx + 1 >= span) ? '0 : tail_idx + 1'b1;
          ring_mem[tail_idx] = word;
        end
        fill++;
      end
    end else if (op == OP_POP_FRONT || op == OP_POP_REAR) begin
      if (fill == '0) begin
        view.accepted = 1'b0;
      end else begin
        if (op == OP_POP_FRONT) begin
          head_idx = (head_idx + 1 >= span) ? '0 : head_idx + 1'b1;
        end else begin
          tail_idx = (tail_idx == '0) ? IdxW'(span - 1) : tail_idx - 1'b1;
        end
        fill--;
        // Drained: both ends go back to slot 0
        if (fill == '0) begin
          head_idx = '0;
          tail_idx = '0;
        end
      end
    end
    view.is_empty = (fill == '0);
    view.is_full  = (fill == span);
    view.front_value = view.is_empty ? EmptyWord : ring_mem[head_idx];
    view.rear_value  = view.is_empty ? EmptyWord : ring_mem[tail_idx];
    return view;
  endfunction

  // Draw a data word, with the extremes turning up now and then
  function automatic logic [WordW-1:0] pick_word();
    logic [WordW-1:0] word;
    case ($urandom_range(0, 11))
      0: word = WordMin;
      1: word = WordMax;
      2: word = EmptyWord;
      3: word = WordZero;
      default: word = $urandom;
    endcase
    return word;
  endfunction

  // Offer one request word; start and end on a falling edge, valid left high
  task automatic send_word(input logic [OpW-1:0] op, input logic [WordW-1:0] word);
    while (!steady && $urandom_range(0, 99) < IdlePct) begin
      deque_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    deque_in.valid     <= 1'b1;
    deque_in.operation <= op;
    deque_in.value     <= word;
    @(posedge clk_i);
    while (!deque_in.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write the capacity once the block has gone idle
  task automatic write_capacity(input logic [CapW-1:0] cap);
    deque_in.valid <= 1'b0;
    @(negedge clk_i);
    while (expected_views.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    deque_cfg.valid    <= 1'b1;
    deque_cfg.capacity <= cap;
    @(posedge clk_i);
    while (!deque_cfg.ready) @(posedge clk_i);
    @(negedge clk_i);
    deque_cfg.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Random mix: push_pct pushes, pop_pct pops, the rest queries and spare codes
  task automatic run_random(input int unsigned count, input int unsigned push_pct,
                            input int unsigned pop_pct);
    int unsigned roll;
    logic [OpW-1:0] op;
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < push_pct) begin
        op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
      end else if (roll < push_pct + pop_pct) begin
        op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
      end else if ($urandom_range(0, 3) == 0) begin
        op = OpW'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end else begin
        op = OP_QUERY;
      end
      send_word(op, pick_word());
    end
  endtask

  // Empty-deque refusals, every operation, spare codes and wrap of the front index
  task automatic test_basic_ops();
    send_word(OP_QUERY, WordZero);
    send_word(OP_POP_FRONT, WordMax);
    send_word(OP_POP_REAR, WordMin);
    send_word(OP_PUSH_FRONT, WordMin);
    send_word(OP_PUSH_REAR, WordMax);
    send_word(OP_PUSH_FRONT, WordZero);
    send_word(OP_PUSH_REAR, EmptyWord);
    send_word(OP_SPARE_LO, WordMax);
    send_word(OP_SPARE_MID, WordMin);
    send_word(OP_SPARE_HI, EmptyWord);
    send_word(OP_POP_FRONT, WordZero);
    send_word(OP_POP_REAR, WordZero);
    send_word(OP_POP_FRONT, WordZero);
    send_word(OP_POP_REAR, WordZero);
    send_word(OP_POP_REAR, WordZero);
    send_word(OP_PUSH_REAR, 32'h1234_5678);
    send_word(OP_PUSH_FRONT, 32'hDEAD_BEEF);
    send_word(OP_POP_REAR, WordZero);
    send_word(OP_POP_FRONT, WordZero);
  endtask

  // Smallest rings: one slot, zero acting as one, and a two-slot wrap
  task automatic test_capacity_edges();
    write_capacity(CapW'(1));
    send_word(OP_PUSH_FRONT, 32'hA5A5_5A5A);
    send_word(OP_PUSH_REAR, WordMax);
    send_word(OP_POP_REAR, WordZero);
    send_word(OP_POP_FRONT, WordZero);
    write_capacity('0);
    send_word(OP_PUSH_REAR, 32'h0F0F_F0F0);
    send_word(OP_PUSH_FRONT, WordMin);
    send_word(OP_POP_FRONT, WordZero);
    write_capacity(CapW'(2));
    send_word(OP_PUSH_REAR, 32'h1111_1111);
    send_word(OP_PUSH_REAR, 32'h2222_2222);
    send_word(OP_PUSH_FRONT, WordMax);
    send_word(OP_POP_FRONT, WordZero);
    send_word(OP_PUSH_REAR, 32'h3333_3333);
    send_word(OP_POP_REAR, WordZero);
    write_capacity(CapW'(1024));
    send_word(OP_QUERY, WordZero);
  endtask

  // Short ring under push-heavy then pop-heavy traffic
  task automatic test_short_ring();
    write_capacity(CapW'(7));
    run_random(150, 70, 20);
    run_random(200, 30, 60);
  endtask

  // One-slot ring flips between empty and full
  task automatic test_single_slot();
    write_capacity(CapW'(1));
    run_random(100, 45, 45);
  endtask

  // Oversized capacity clamps to the built depth; fill it, overflow, then pop-heavy traffic
  task automatic test_full_depth();
    write_capacity('1);
    steady = 1'b1;
    for (int unsigned n = 0; n < DEPTH + 6; n++) begin
      if (n == 300) steady = 1'b0;
      send_word($urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT, pick_word());
    end
    run_random(400, 20, 75);
  endtask

  // Receiver side: stall at random except while steady
  always @(negedge clk_i) begin
    deque_out.ready <= steady || ($urandom_range(0, 99) >= IdlePct);
  end

  // Check results, track capacity writes and predict each accepted request
  always @(posedge clk_i) begin
    deque_view_t want;
    deque_view_t got;
    if (rst_ni) begin
      if (deque_out.valid && deque_out.ready) begin
        got = {deque_out.accepted, deque_out.front_value, deque_out.rear_value,
               deque_out.is_empty, deque_out.is_full};
        if (expected_views.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportLimit) begin
            $display("ERROR: result with nothing expected: acc=%0b front=%h rear=%h",
                     got.accepted, got.front_value, got.rear_value);
          end
        end else begin
          want = expected_views.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= ReportLimit) begin
              $display({"ERROR: expected acc=%0b front=%h rear=%h empty=%0b full=%0b,",
                        " got acc=%0b front=%h rear=%h empty=%0b full=%0b"},
                       want.accepted, want.front_value, want.rear_value, want.is_empty,
                       want.is_full, got.accepted, got.front_value, got.rear_value,
                       got.is_empty, got.is_full);
            end
          end
        end
      end
      // A capacity write empties the deque
      if (deque_cfg.valid && deque_cfg.ready) begin
        cap_reg  = deque_cfg.capacity;
        fill     = '0;
        head_idx = '0;
        tail_idx = '0;
      end
      if (deque_in.valid && deque_in.ready) begin
        expected_views.push_back(step_deque(deque_in.operation, deque_in.value));
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (deque_in.valid && deque_in.ready) || (deque_out.valid && deque_out.ready)
        || (deque_cfg.valid && deque_cfg.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_ni              = 1'b0;
    steady              = 1'b0;
    fail_count          = 0;
    quiet_cycles        = 0;
    deque_in.valid      = 1'b0;
    deque_in.operation  = OP_QUERY;
    deque_in.value      = '0;
    deque_out.ready     = 1'b0;
    deque_cfg.valid     = 1'b0;
    deque_cfg.capacity  = CapReset;
    fill                = '0;
    head_idx            = '0;
    tail_idx            = '0;
    cap_reg             = CapReset;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_basic_ops();
    test_capacity_edges();
    test_short_ring();
    test_single_slot();
    test_full_depth();

    // Drain outstanding results, then let the pipeline settle
    deque_in.valid <= 1'b0;
    @(negedge clk_i);
    while (expected_views.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
src/cdq_pkg.sv
src/cdq_if.sv
src/cdq_ram.sv
src/cdq_ctrl.sv
src/circular_deque_core.sv
tb/circular_deque_core_test.sv
